[design/vtc_pkg.sv]
// ----------------------------------------------------------------------------
// vtc_pkg
// Shared types, byte codes and code point tables for the cursor tracker.
// ----------------------------------------------------------------------------
package vtc_pkg;

    localparam int MAX_PARAMS_DEF = 16;
    localparam int TAB_SHIFT      = 3;
    localparam int FIFO_DEPTH     = 4;

    localparam logic [12:0] COLS_RESET = 13'd80;
    localparam logic [12:0] ROWS_RESET = 13'd25;

    localparam logic [7:0] B_BEL    = 8'h07;
    localparam logic [7:0] B_ESC    = 8'h1B;
    localparam logic [7:0] B_LBRK   = 8'h5B;
    localparam logic [7:0] B_RBRK   = 8'h5D;
    localparam logic [7:0] B_BSLASH = 8'h5C;
    localparam logic [7:0] B_P      = 8'h50;
    localparam logic [7:0] B_USCORE = 8'h5F;
    localparam logic [7:0] B_CARET  = 8'h5E;
    localparam logic [7:0] B_LPAR   = 8'h28;
    localparam logic [7:0] B_RPAR   = 8'h29;
    localparam logic [7:0] B_STAR   = 8'h2A;
    localparam logic [7:0] B_PLUS   = 8'h2B;
    localparam logic [7:0] B_7      = 8'h37;
    localparam logic [7:0] B_8      = 8'h38;
    localparam logic [7:0] B_0      = 8'h30;
    localparam logic [7:0] B_9      = 8'h39;
    localparam logic [7:0] B_SEMI   = 8'h3B;
    localparam logic [7:0] B_COLON  = 8'h3A;
    localparam logic [7:0] B_QMARK  = 8'h3F;
    localparam logic [7:0] B_AT     = 8'h40;
    localparam logic [7:0] B_TILDE  = 8'h7E;
    localparam logic [7:0] B_UA     = 8'h41;
    localparam logic [7:0] B_UB     = 8'h42;
    localparam logic [7:0] B_UC     = 8'h43;
    localparam logic [7:0] B_UD     = 8'h44;
    localparam logic [7:0] B_UE     = 8'h45;
    localparam logic [7:0] B_UF     = 8'h46;
    localparam logic [7:0] B_UG     = 8'h47;
    localparam logic [7:0] B_UH     = 8'h48;
    localparam logic [7:0] B_UI     = 8'h49;
    localparam logic [7:0] B_UJ     = 8'h4A;
    localparam logic [7:0] B_UM     = 8'h4D;
    localparam logic [7:0] B_US     = 8'h53;
    localparam logic [7:0] B_UZ     = 8'h5A;
    localparam logic [7:0] B_BTICK  = 8'h60;
    localparam logic [7:0] B_LA     = 8'h61;
    localparam logic [7:0] B_LC     = 8'h63;
    localparam logic [7:0] B_LD     = 8'h64;
    localparam logic [7:0] B_LE     = 8'h65;
    localparam logic [7:0] B_LF_    = 8'h66;
    localparam logic [7:0] B_LH     = 8'h68;
    localparam logic [7:0] B_LL     = 8'h6C;
    localparam logic [7:0] B_LR     = 8'h72;
    localparam logic [7:0] B_LS     = 8'h73;
    localparam logic [7:0] B_LU     = 8'h75;

    localparam logic [15:0] MODE_AWM    = 16'd7;
    localparam logic [15:0] MODE_ALT47  = 16'd47;
    localparam logic [15:0] MODE_ALT    = 16'd1047;
    localparam logic [15:0] MODE_SAVE   = 16'd1048;
    localparam logic [15:0] MODE_ALTSAV = 16'd1049;

    typedef enum logic [4:0] {
        OP_NOP, OP_CR, OP_LF, OP_BS, OP_TAB, OP_PUT,
        OP_IND, OP_RI, OP_NEL, OP_SAVE, OP_RESTORE, OP_RIS,
        OP_CUP, OP_CUU, OP_CUD, OP_CUF, OP_CUB, OP_CNL, OP_CPL,
        OP_CHA, OP_VPA, OP_CHT, OP_CBT, OP_SU, OP_STBM, OP_SBCLR,
        OP_AWM_ON, OP_AWM_OFF, OP_ALT_ON, OP_ALT_OFF, OP_ALTS_ON, OP_ALTS_OFF
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] a0;
        logic [15:0] a1;
        logic [1:0]  width;
        logic        flag;
        logic        clamp;
        logic        last;
    } cmd_t;

    function automatic logic in_rng(input logic [20:0] cp, input logic [20:0] lo,
                                    input logic [20:0] hi);
        return (cp >= lo) && (cp <= hi);
    endfunction

    function automatic logic [1:0] cp_width(input logic [20:0] cp);
        logic z;
        logic w;
        z = in_rng(cp, 21'h80, 21'h9F) || in_rng(cp, 21'hAD, 21'hAD)
            || in_rng(cp, 21'h300, 21'h36F) || in_rng(cp, 21'h483, 21'h489)
            || in_rng(cp, 21'h591, 21'h5BD) || in_rng(cp, 21'h610, 21'h61A)
            || in_rng(cp, 21'h64B, 21'h65F) || in_rng(cp, 21'h1160, 21'h11FF)
            || in_rng(cp, 21'h200B, 21'h200F) || in_rng(cp, 21'h202A, 21'h202E)
            || in_rng(cp, 21'h2060, 21'h2064) || in_rng(cp, 21'h20D0, 21'h20FF)
            || in_rng(cp, 21'hD800, 21'hDFFF) || in_rng(cp, 21'hFE00, 21'hFE0F)
            || in_rng(cp, 21'hFE20, 21'hFE2F) || in_rng(cp, 21'hFEFF, 21'hFEFF)
            || in_rng(cp, 21'hE0100, 21'hE01EF) || in_rng(cp, 21'h110000, 21'h1FFFFF);
        w = in_rng(cp, 21'h1100, 21'h115F) || in_rng(cp, 21'h2E80, 21'h303E)
            || in_rng(cp, 21'h3041, 21'h33FF) || in_rng(cp, 21'h3400, 21'h4DBF)
            || in_rng(cp, 21'h4E00, 21'h9FFF) || in_rng(cp, 21'hA000, 21'hA4CF)
            || in_rng(cp, 21'hAC00, 21'hD7A3) || in_rng(cp, 21'hF900, 21'hFAFF)
            || in_rng(cp, 21'hFE30, 21'hFE4F) || in_rng(cp, 21'hFF00, 21'hFF60)
            || in_rng(cp, 21'hFFE0, 21'hFFE6) || in_rng(cp, 21'h1F300, 21'h1F64F)
            || in_rng(cp, 21'h1F900, 21'h1F9FF) || in_rng(cp, 21'h20000, 21'h2FFFD)
            || in_rng(cp, 21'h30000, 21'h3FFFD);
        if (z)
            return 2'd0;
        else if (w)
            return 2'd2;
        else
            return 2'd1;
    endfunction

    function automatic cmd_t cp_cmd(input logic [20:0] cp);
        cmd_t c;
        c       = '0;
        c.op    = OP_NOP;
        c.last  = 1'b1;
        if (cp == 21'h0D)
            c.op = OP_CR;
        else if (cp == 21'h0A)
            c.op = OP_LF;
        else if (cp == 21'h08)
            c.op = OP_BS;
        else if (cp == 21'h09)
            c.op = OP_TAB;
        else if (cp < 21'h20 || cp == 21'h7F)
            c.op = OP_NOP;
        else
        begin
            c.op    = OP_PUT;
            c.width = cp_width(cp);
        end
        return c;
    endfunction

endpackage

[design/vtc_byte_if.sv]
// ----------------------------------------------------------------------------
// vtc_byte_if
// Input byte channel: valid/ready with one stream byte per transfer.
// ----------------------------------------------------------------------------
interface vtc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

[design/vtc_result_if.sv]
// ----------------------------------------------------------------------------
// vtc_result_if
// Result channel: valid/ready with cursor report per transfer.
// ----------------------------------------------------------------------------
interface vtc_result_if;
    logic        valid;
    logic        ready;
    logic [11:0] cursor_col;
    logic [11:0] cursor_row;
    logic        wrap_pending;
    logic [15:0] scrolled_lines;
    logic        scrollback_clear;
    logic        alt_screen_on;

    modport source (output valid, output cursor_col, output cursor_row,
                    output wrap_pending, output scrolled_lines,
                    output scrollback_clear, output alt_screen_on, input ready);
    modport sink (input valid, input cursor_col, input cursor_row,
                  input wrap_pending, input scrolled_lines,
                  input scrollback_clear, input alt_screen_on, output ready);
endinterface

[design/vtc_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// vtc_cmd_fifo
// Small command queue between parser front and cursor back.
// ----------------------------------------------------------------------------
module vtc_cmd_fifo
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  vtc_pkg::cmd_t wdata,
    output logic          full,
    input  logic          pop,
    output vtc_pkg::cmd_t rdata,
    output logic          nonempty
);
    localparam int PW = $clog2(vtc_pkg::FIFO_DEPTH);

    vtc_pkg::cmd_t     mem_reg [vtc_pkg::FIFO_DEPTH];
    logic [PW-1:0]     wp_reg, wp_next, rp_reg, rp_next;
    logic [PW:0]       cnt_reg, cnt_next;

    assign full     = (cnt_reg == (PW+1)'(vtc_pkg::FIFO_DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign rdata    = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? wp_reg + PW'(1) : wp_reg;
        rp_next  = pop ? rp_reg + PW'(1) : rp_reg;
        cnt_next = cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

[design/vtc_front.sv]
// ----------------------------------------------------------------------------
// vtc_front
// Escape parser and UTF-8 decoder; turns bytes into cursor commands.
// ----------------------------------------------------------------------------
module vtc_front #(
    parameter int MAX_PARAMS = vtc_pkg::MAX_PARAMS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    vtc_byte_if.sink      in_ch,
    output logic          push,
    output vtc_pkg::cmd_t push_cmd,
    input  logic          full
);
    localparam int CW = $clog2(MAX_PARAMS + 1);
    localparam int IW = $clog2(MAX_PARAMS);

    typedef enum logic [1:0] { F_ACCEPT = 2'b01, F_DISP = 2'b10 } fst_t;
    typedef enum logic [4:0] {
        M_GROUND  = 5'b00001,
        M_ESC     = 5'b00010,
        M_CSI     = 5'b00100,
        M_STRING  = 5'b01000,
        M_CHARSET = 5'b10000
    } mode_t;

    fst_t          fst_reg, fst_next;
    mode_t         mode_reg, mode_next;
    logic          sesc_reg, sesc_next;
    logic [20:0]   acc_reg, acc_next;
    logic [2:0]    have_reg, have_next, want_reg, want_next;
    logic [15:0]   store_reg [MAX_PARAMS];
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [15:0]   cur_reg, cur_next;
    logic          seen_reg, seen_next, priv_reg, priv_next;
    logic [7:0]    fin_reg, fin_next;
    logic [IW-1:0] walk_reg, walk_next;

    logic          st_we;
    logic [IW-1:0] st_wa;
    logic [7:0]    b;
    logic [20:0]   acc2;
    logic [2:0]    have2;
    logic [19:0]   dec;
    logic          wlast;
    vtc_pkg::cmd_t c;

    function automatic logic [15:0] argv(input logic seen, input logic [CW-1:0] cnt,
                                         input int idx, input logic [15:0] v);
        if (seen && cnt > CW'(idx))
            return (v == 16'd0) ? 16'd1 : v;
        return 16'd1;
    endfunction

    function automatic vtc_pkg::op_t decset_op(input logic [15:0] v, input logic on);
        if (v == vtc_pkg::MODE_AWM)
            return on ? vtc_pkg::OP_AWM_ON : vtc_pkg::OP_AWM_OFF;
        else if (v == vtc_pkg::MODE_ALT47 || v == vtc_pkg::MODE_ALT)
            return on ? vtc_pkg::OP_ALT_ON : vtc_pkg::OP_ALT_OFF;
        else if (v == vtc_pkg::MODE_SAVE)
            return on ? vtc_pkg::OP_SAVE : vtc_pkg::OP_RESTORE;
        else if (v == vtc_pkg::MODE_ALTSAV)
            return on ? vtc_pkg::OP_ALTS_ON : vtc_pkg::OP_ALTS_OFF;
        return vtc_pkg::OP_NOP;
    endfunction

    function automatic vtc_pkg::op_t csi_op(input logic [7:0] f, input logic ed3);
        vtc_pkg::op_t o;
        unique case (f)
            vtc_pkg::B_UH, vtc_pkg::B_LF_:   o = vtc_pkg::OP_CUP;
            vtc_pkg::B_UA:                   o = vtc_pkg::OP_CUU;
            vtc_pkg::B_UB, vtc_pkg::B_LE:    o = vtc_pkg::OP_CUD;
            vtc_pkg::B_UC, vtc_pkg::B_LA:    o = vtc_pkg::OP_CUF;
            vtc_pkg::B_UD:                   o = vtc_pkg::OP_CUB;
            vtc_pkg::B_UE:                   o = vtc_pkg::OP_CNL;
            vtc_pkg::B_UF:                   o = vtc_pkg::OP_CPL;
            vtc_pkg::B_UG, vtc_pkg::B_BTICK: o = vtc_pkg::OP_CHA;
            vtc_pkg::B_LD:                   o = vtc_pkg::OP_VPA;
            vtc_pkg::B_UI:                   o = vtc_pkg::OP_CHT;
            vtc_pkg::B_UZ:                   o = vtc_pkg::OP_CBT;
            vtc_pkg::B_US:                   o = vtc_pkg::OP_SU;
            vtc_pkg::B_LR:                   o = vtc_pkg::OP_STBM;
            vtc_pkg::B_UJ:                   o = ed3 ? vtc_pkg::OP_SBCLR : vtc_pkg::OP_NOP;
            vtc_pkg::B_LS:                   o = vtc_pkg::OP_SAVE;
            vtc_pkg::B_LU:                   o = vtc_pkg::OP_RESTORE;
            default:                         o = vtc_pkg::OP_NOP;
        endcase
        return o;
    endfunction

    assign in_ch.ready = (fst_reg == F_ACCEPT) && !full;
    assign b           = in_ch.data_byte;

    always_comb
    begin
        fst_next  = fst_reg;
        mode_next = mode_reg;
        sesc_next = sesc_reg;
        acc_next  = acc_reg;
        have_next = have_reg;
        want_next = want_reg;
        cnt_next  = cnt_reg;
        cur_next  = cur_reg;
        seen_next = seen_reg;
        priv_next = priv_reg;
        fin_next  = fin_reg;
        walk_next = walk_reg;
        st_we     = 1'b0;
        st_wa     = cnt_reg[IW-1:0];
        acc2      = {acc_reg[14:0], b[5:0]};
        have2     = have_reg + 3'd1;
        dec       = (20'(cur_reg) << 3) + (20'(cur_reg) << 1) + 20'(b[3:0]);
        wlast     = ((CW'(walk_reg) + CW'(1)) == cnt_reg);
        c         = '0;
        c.op      = vtc_pkg::OP_NOP;
        c.last    = 1'b1;
        push      = 1'b0;

        if (fst_reg == F_ACCEPT)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                push = 1'b1;
                unique case (mode_reg)
                    M_GROUND:
                    begin
                        if (b == vtc_pkg::B_ESC)
                            mode_next = M_ESC;
                        else if (!b[7])
                            c = vtc_pkg::cp_cmd({13'd0, b});
                        else if (have_reg == 3'd0)
                        begin
                            priority if (b[7:5] == 3'b110)
                            begin
                                want_next = 3'd2;
                                acc_next  = {16'd0, b[4:0]};
                                have_next = 3'd1;
                            end
                            else if (b[7:4] == 4'b1110)
                            begin
                                want_next = 3'd3;
                                acc_next  = {17'd0, b[3:0]};
                                have_next = 3'd1;
                            end
                            else if (b[7:3] == 5'b11110)
                            begin
                                want_next = 3'd4;
                                acc_next  = {18'd0, b[2:0]};
                                have_next = 3'd1;
                            end
                            else
                            begin
                                want_next = want_reg;
                            end
                        end
                        else if (have2 >= want_reg)
                        begin
                            c         = vtc_pkg::cp_cmd(acc2);
                            acc_next  = '0;
                            have_next = '0;
                            want_next = '0;
                        end
                        else
                        begin
                            acc_next  = acc2;
                            have_next = have2;
                        end
                    end
                    M_ESC:
                    begin
                        mode_next = M_GROUND;
                        if (b == vtc_pkg::B_LBRK)
                        begin
                            cnt_next  = '0;
                            cur_next  = '0;
                            seen_next = 1'b0;
                            priv_next = 1'b0;
                            mode_next = M_CSI;
                        end
                        else if (b == vtc_pkg::B_RBRK || b == vtc_pkg::B_P
                                 || b == vtc_pkg::B_USCORE || b == vtc_pkg::B_CARET)
                        begin
                            sesc_next = 1'b0;
                            mode_next = M_STRING;
                        end
                        else if (b == vtc_pkg::B_LPAR || b == vtc_pkg::B_RPAR
                                 || b == vtc_pkg::B_STAR || b == vtc_pkg::B_PLUS)
                            mode_next = M_CHARSET;
                        else if (b == vtc_pkg::B_7)
                            c.op = vtc_pkg::OP_SAVE;
                        else if (b == vtc_pkg::B_8)
                            c.op = vtc_pkg::OP_RESTORE;
                        else if (b == vtc_pkg::B_UD)
                            c.op = vtc_pkg::OP_IND;
                        else if (b == vtc_pkg::B_UM)
                            c.op = vtc_pkg::OP_RI;
                        else if (b == vtc_pkg::B_UE)
                            c.op = vtc_pkg::OP_NEL;
                        else if (b == vtc_pkg::B_LC)
                            c.op = vtc_pkg::OP_RIS;
                    end
                    M_CSI:
                    begin
                        if (b >= vtc_pkg::B_0 && b <= vtc_pkg::B_9)
                        begin
                            cur_next  = (dec > 20'd65535) ? 16'hFFFF : dec[15:0];
                            seen_next = 1'b1;
                        end
                        else if (b == vtc_pkg::B_SEMI || b == vtc_pkg::B_COLON
                                 || (b >= vtc_pkg::B_AT && b <= vtc_pkg::B_TILDE))
                        begin
                            if (cnt_reg < CW'(MAX_PARAMS))
                            begin
                                st_we    = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                            end
                            cur_next = '0;
                            if (b >= vtc_pkg::B_AT)
                            begin
                                push      = 1'b0;
                                fin_next  = b;
                                walk_next = '0;
                                fst_next  = F_DISP;
                            end
                            else
                                seen_next = 1'b1;
                        end
                        else if (b == vtc_pkg::B_QMARK)
                            priv_next = 1'b1;
                        else if (b == vtc_pkg::B_ESC)
                        begin
                            cnt_next  = '0;
                            cur_next  = '0;
                            seen_next = 1'b0;
                            priv_next = 1'b0;
                            mode_next = M_ESC;
                        end
                    end
                    M_STRING:
                    begin
                        if (sesc_reg)
                        begin
                            if (b == vtc_pkg::B_BSLASH)
                                mode_next = M_GROUND;
                            sesc_next = 1'b0;
                        end
                        else if (b == vtc_pkg::B_BEL)
                            mode_next = M_GROUND;
                        else if (b == vtc_pkg::B_ESC)
                            sesc_next = 1'b1;
                    end
                    default:
                        mode_next = M_GROUND;
                endcase
            end
        end
        else if (!full)
        begin
            push = 1'b1;
            if (fin_reg == vtc_pkg::B_LH || fin_reg == vtc_pkg::B_LL)
            begin
                if (priv_reg)
                begin
                    c.op    = decset_op(store_reg[walk_reg], fin_reg == vtc_pkg::B_LH);
                    c.last  = wlast;
                    c.clamp = wlast;
                end
            end
            else
            begin
                c.op    = csi_op(fin_reg, seen_reg && (cnt_reg != '0)
                                 && (store_reg[0] == 16'd3));
                c.clamp = 1'b1;
                if (c.op == vtc_pkg::OP_STBM)
                begin
                    c.a0   = store_reg[0];
                    c.a1   = store_reg[1];
                    c.flag = (cnt_reg >= CW'(2));
                end
                else
                begin
                    c.a0 = argv(seen_reg, cnt_reg, 0, store_reg[0]);
                    c.a1 = argv(seen_reg, cnt_reg, 1, store_reg[1]);
                end
            end
            if (c.last)
            begin
                fst_next  = F_ACCEPT;
                mode_next = M_GROUND;
                cnt_next  = '0;
                cur_next  = '0;
                seen_next = 1'b0;
                priv_next = 1'b0;
            end
            else
                walk_next = walk_reg + IW'(1);
        end
        push_cmd = c;
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
            store_reg[st_wa] <= cur_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fst_reg  <= F_ACCEPT;
            mode_reg <= M_GROUND;
            sesc_reg <= 1'b0;
            acc_reg  <= '0;
            have_reg <= '0;
            want_reg <= '0;
            cnt_reg  <= '0;
            cur_reg  <= '0;
            seen_reg <= 1'b0;
            priv_reg <= 1'b0;
            fin_reg  <= '0;
            walk_reg <= '0;
        end
        else
        begin
            fst_reg  <= fst_next;
            mode_reg <= mode_next;
            sesc_reg <= sesc_next;
            acc_reg  <= acc_next;
            have_reg <= have_next;
            want_reg <= want_next;
            cnt_reg  <= cnt_next;
            cur_reg  <= cur_next;
            seen_reg <= seen_next;
            priv_reg <= priv_next;
            fin_reg  <= fin_next;
            walk_reg <= walk_next;
        end
    end
endmodule

[design/vtc_back.sv]
// ----------------------------------------------------------------------------
// vtc_back
// Cursor engine: executes commands, iterates tab steps, holds the result.
// ----------------------------------------------------------------------------
module vtc_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  vtc_pkg::cmd_t cmd,
    input  logic          cmd_valid,
    output logic          pop,
    input  logic [11:0]   cmax,
    input  logic [11:0]   rmax,
    vtc_result_if.source  out_ch
);
    typedef enum logic [1:0] { B_EXEC = 2'b01, B_ITER = 2'b10 } bst_t;

    bst_t        st_reg, st_next;
    logic [15:0] col_reg, col_next, row_reg, row_next;
    logic        pw_reg, pw_next, awm_reg, awm_next;
    logic        ra_reg, ra_next;
    logic [11:0] rt_reg, rt_next, rb_reg, rb_next;
    logic        sok_reg, sok_next, sw_reg, sw_next;
    logic [15:0] scol_reg, scol_next, srow_reg, srow_next;
    logic        alt_reg, alt_next;
    logic [15:0] acol_reg, acol_next, arow_reg, arow_next;
    logic [15:0] cnt_reg, cnt_next;
    logic        cbt_reg, cbt_next;

    logic        ov_reg, ov_next;
    logic [11:0] ocol_reg, ocol_next, orow_reg, orow_next;
    logic        opw_reg, opw_next, osb_reg, osb_next, oalt_reg, oalt_next;
    logic [15:0] oscr_reg, oscr_next;

    logic        can_out, emit, clamp;
    logic [15:0] scr, cmax16, rmax16, p2c;
    logic        sb;
    logic [16:0] lfr, sum, nx, cols17;
    logic [12:0] rows13;

    function automatic logic [16:0] lf_step(input logic [15:0] r, input logic ra,
                                            input logic [11:0] rb, input logic [11:0] rm);
        logic [15:0] bot;
        bot = ra ? {4'd0, rb} : {4'd0, rm};
        if ({1'b0, r} + 17'd1 > {1'b0, bot})
            return {~ra, bot};
        return {1'b0, r + 16'd1};
    endfunction

    assign can_out = !ov_reg || out_ch.ready;
    assign cmax16  = {4'd0, cmax};
    assign rmax16  = {4'd0, rmax};
    assign cols17  = {5'd0, cmax} + 17'd1;
    assign rows13  = {1'b0, rmax} + 13'd1;

    always_comb
    begin
        st_next   = st_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        pw_next   = pw_reg;
        awm_next  = awm_reg;
        ra_next   = ra_reg;
        rt_next   = rt_reg;
        rb_next   = rb_reg;
        sok_next  = sok_reg;
        sw_next   = sw_reg;
        scol_next = scol_reg;
        srow_next = srow_reg;
        alt_next  = alt_reg;
        acol_next = acol_reg;
        arow_next = arow_reg;
        cnt_next  = cnt_reg;
        cbt_next  = cbt_reg;
        pop       = 1'b0;
        emit      = 1'b0;
        clamp     = 1'b0;
        scr       = '0;
        sb        = 1'b0;
        lfr       = '0;
        sum       = '0;
        p2c       = '0;
        nx        = (17'(col_reg >> vtc_pkg::TAB_SHIFT) + 17'd1) << vtc_pkg::TAB_SHIFT;

        unique case (st_reg)
            B_EXEC:
            begin
                if (cmd_valid && can_out)
                begin
                    pop   = 1'b1;
                    emit  = cmd.last;
                    clamp = cmd.clamp;
                    unique case (cmd.op)
                        vtc_pkg::OP_CR:
                        begin
                            col_next = '0;
                            pw_next  = 1'b0;
                        end
                        vtc_pkg::OP_LF, vtc_pkg::OP_NEL, vtc_pkg::OP_IND:
                        begin
                            if (cmd.op != vtc_pkg::OP_IND)
                                col_next = '0;
                            if (cmd.op == vtc_pkg::OP_LF)
                                pw_next = 1'b0;
                            lfr      = lf_step(row_reg, ra_reg, rb_reg, rmax);
                            row_next = lfr[15:0];
                            scr      = 16'(lfr[16]);
                        end
                        vtc_pkg::OP_BS:
                        begin
                            pw_next = 1'b0;
                            if (col_reg != '0)
                                col_next = col_reg - 16'd1;
                        end
                        vtc_pkg::OP_TAB:
                            col_next = (nx < cols17) ? nx[15:0] : cmax16;
                        vtc_pkg::OP_PUT:
                        begin
                            if (pw_reg)
                            begin
                                pw_next  = 1'b0;
                                col_next = '0;
                                lfr      = lf_step(row_reg, ra_reg, rb_reg, rmax);
                                row_next = lfr[15:0];
                                scr      = 16'(lfr[16]);
                            end
                            if (cmd.width != 2'd0)
                            begin
                                sum = {1'b0, col_next} + {15'd0, cmd.width};
                                if (sum > {5'd0, cmax})
                                begin
                                    if (awm_reg)
                                    begin
                                        if (cmd.width == 2'd1 && col_next == cmax16)
                                            pw_next = 1'b1;
                                        else
                                        begin
                                            lfr      = lf_step(row_next, ra_reg, rb_reg, rmax);
                                            row_next = lfr[15:0];
                                            scr      = scr + 16'(lfr[16]);
                                            col_next = {14'd0, cmd.width};
                                        end
                                    end
                                    else
                                        col_next = cmax16;
                                end
                                else
                                    col_next = sum[15:0];
                            end
                        end
                        vtc_pkg::OP_RI:
                        begin
                            if (row_reg <= (ra_reg ? {4'd0, rt_reg} : 16'd0))
                                row_next = ra_reg ? {4'd0, rt_reg} : 16'd0;
                            else
                                row_next = row_reg - 16'd1;
                        end
                        vtc_pkg::OP_SAVE:
                        begin
                            sok_next  = 1'b1;
                            scol_next = col_reg;
                            srow_next = row_reg;
                            sw_next   = pw_reg;
                        end
                        vtc_pkg::OP_RESTORE:
                        begin
                            if (sok_reg)
                            begin
                                col_next = scol_reg;
                                row_next = srow_reg;
                                pw_next  = sw_reg;
                            end
                        end
                        vtc_pkg::OP_RIS:
                        begin
                            awm_next = 1'b1;
                            alt_next = 1'b0;
                            ra_next  = 1'b0;
                            col_next = '0;
                            row_next = '0;
                            pw_next  = 1'b0;
                            sok_next = 1'b0;
                            sb       = 1'b1;
                        end
                        vtc_pkg::OP_CUP:
                        begin
                            row_next = cmd.a0 - 16'd1;
                            col_next = cmd.a1 - 16'd1;
                            pw_next  = 1'b0;
                        end
                        vtc_pkg::OP_CUU, vtc_pkg::OP_CPL:
                        begin
                            row_next = (row_reg > cmd.a0) ? row_reg - cmd.a0 : 16'd0;
                            if (cmd.op == vtc_pkg::OP_CPL)
                                col_next = '0;
                        end
                        vtc_pkg::OP_CUD, vtc_pkg::OP_CNL:
                        begin
                            sum      = {1'b0, row_reg} + {1'b0, cmd.a0};
                            row_next = sum[16] ? 16'hFFFF : sum[15:0];
                            if (cmd.op == vtc_pkg::OP_CNL)
                                col_next = '0;
                        end
                        vtc_pkg::OP_CUF:
                        begin
                            sum      = {1'b0, col_reg} + {1'b0, cmd.a0};
                            col_next = sum[16] ? 16'hFFFF : sum[15:0];
                            pw_next  = 1'b0;
                        end
                        vtc_pkg::OP_CUB:
                        begin
                            col_next = (col_reg > cmd.a0) ? col_reg - cmd.a0 : 16'd0;
                            pw_next  = 1'b0;
                        end
                        vtc_pkg::OP_CHA:
                        begin
                            col_next = cmd.a0 - 16'd1;
                            pw_next  = 1'b0;
                        end
                        vtc_pkg::OP_VPA:
                            row_next = cmd.a0 - 16'd1;
                        vtc_pkg::OP_CHT, vtc_pkg::OP_CBT:
                        begin
                            emit     = 1'b0;
                            clamp    = 1'b0;
                            cnt_next = cmd.a0;
                            cbt_next = (cmd.op == vtc_pkg::OP_CBT);
                            st_next  = B_ITER;
                        end
                        vtc_pkg::OP_SU:
                            scr = ra_reg ? 16'd0 : cmd.a0;
                        vtc_pkg::OP_STBM:
                        begin
                            pw_next = 1'b0;
                            p2c     = (cmd.a1 > {3'd0, rows13}) ? {3'd0, rows13} : cmd.a1;
                            if (!cmd.flag || (cmd.a0 == 16'd0 && cmd.a1 == 16'd0))
                            begin
                                ra_next  = 1'b0;
                                col_next = '0;
                                row_next = '0;
                            end
                            else if (cmd.a0 >= 16'd1 && p2c >= 16'd1 && cmd.a0 < p2c)
                            begin
                                ra_next  = 1'b1;
                                rt_next  = cmd.a0[11:0] - 12'd1;
                                rb_next  = p2c[11:0] - 12'd1;
                                col_next = '0;
                                row_next = {4'd0, cmd.a0[11:0] - 12'd1};
                            end
                        end
                        vtc_pkg::OP_SBCLR:
                            sb = 1'b1;
                        vtc_pkg::OP_AWM_ON:
                            awm_next = 1'b1;
                        vtc_pkg::OP_AWM_OFF:
                        begin
                            awm_next = 1'b0;
                            pw_next  = 1'b0;
                        end
                        vtc_pkg::OP_ALT_ON, vtc_pkg::OP_ALTS_ON:
                        begin
                            if (!alt_reg)
                            begin
                                if (cmd.op == vtc_pkg::OP_ALTS_ON)
                                begin
                                    sok_next  = 1'b1;
                                    scol_next = col_reg;
                                    srow_next = row_reg;
                                    sw_next   = pw_reg;
                                end
                                alt_next  = 1'b1;
                                acol_next = col_reg;
                                arow_next = row_reg;
                            end
                        end
                        vtc_pkg::OP_ALT_OFF:
                            alt_next = 1'b0;
                        vtc_pkg::OP_ALTS_OFF:
                        begin
                            if (alt_reg)
                            begin
                                alt_next = 1'b0;
                                col_next = acol_reg;
                                row_next = arow_reg;
                                pw_next  = 1'b0;
                            end
                        end
                        default:
                            scr = '0;
                    endcase
                end
            end
            B_ITER:
            begin
                if (cnt_reg == '0 || (cbt_reg && col_reg == '0))
                begin
                    if (can_out)
                    begin
                        pw_next = 1'b0;
                        clamp   = 1'b1;
                        emit    = 1'b1;
                        st_next = B_EXEC;
                    end
                end
                else if (cbt_reg)
                begin
                    col_next = ((col_reg - 16'd1) >> vtc_pkg::TAB_SHIFT) << vtc_pkg::TAB_SHIFT;
                    cnt_next = cnt_reg - 16'd1;
                end
                else if (nx >= cols17)
                begin
                    col_next = cmax16;
                    cnt_next = '0;
                end
                else
                begin
                    col_next = nx[15:0];
                    cnt_next = cnt_reg - 16'd1;
                end
            end
            default:
                st_next = B_EXEC;
        endcase

        if (clamp)
        begin
            if (col_next > cmax16)
                col_next = cmax16;
            if (row_next > rmax16)
                row_next = rmax16;
        end

        ov_next   = emit ? 1'b1 : (ov_reg && !out_ch.ready);
        ocol_next = emit ? ((col_next > cmax16) ? cmax : col_next[11:0]) : ocol_reg;
        orow_next = emit ? ((row_next > rmax16) ? rmax : row_next[11:0]) : orow_reg;
        opw_next  = emit ? pw_next : opw_reg;
        oscr_next = emit ? scr : oscr_reg;
        osb_next  = emit ? sb : osb_reg;
        oalt_next = emit ? alt_next : oalt_reg;
    end

    assign out_ch.valid            = ov_reg;
    assign out_ch.cursor_col       = ocol_reg;
    assign out_ch.cursor_row       = orow_reg;
    assign out_ch.wrap_pending     = opw_reg;
    assign out_ch.scrolled_lines   = oscr_reg;
    assign out_ch.scrollback_clear = osb_reg;
    assign out_ch.alt_screen_on    = oalt_reg;

    always_ff @(posedge clk)
    begin
        ocol_reg <= ocol_next;
        orow_reg <= orow_next;
        opw_reg  <= opw_next;
        oscr_reg <= oscr_next;
        osb_reg  <= osb_next;
        oalt_reg <= oalt_next;
        cnt_reg  <= cnt_next;
        cbt_reg  <= cbt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= B_EXEC;
            ov_reg   <= 1'b0;
            col_reg  <= '0;
            row_reg  <= '0;
            pw_reg   <= 1'b0;
            awm_reg  <= 1'b1;
            ra_reg   <= 1'b0;
            rt_reg   <= '0;
            rb_reg   <= '0;
            sok_reg  <= 1'b0;
            sw_reg   <= 1'b0;
            scol_reg <= '0;
            srow_reg <= '0;
            alt_reg  <= 1'b0;
            acol_reg <= '0;
            arow_reg <= '0;
        end
        else
        begin
            st_reg   <= st_next;
            ov_reg   <= ov_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            pw_reg   <= pw_next;
            awm_reg  <= awm_next;
            ra_reg   <= ra_next;
            rt_reg   <= rt_next;
            rb_reg   <= rb_next;
            sok_reg  <= sok_next;
            sw_reg   <= sw_next;
            scol_reg <= scol_next;
            srow_reg <= srow_next;
            alt_reg  <= alt_next;
            acol_reg <= acol_next;
            arow_reg <= arow_next;
        end
    end
endmodule

[design/vt_escape_cursor_tracker.sv]
// ----------------------------------------------------------------------------
// vt_escape_cursor_tracker
// Terminal byte stream in, tracked cursor position out, one result per byte.
//
//   port        dir    transfer
//   in_ch       sink   one stream byte
//   out_ch      source one cursor report
//   cfg_*       write  screen_columns (0), screen_rows (1)
//
// Most bytes: decoded in the parser, then executed in the cursor engine.
// CSI finals: dispatched from a separate state; private h/l issue one command per parameter.
// CSI I / Z: the cursor engine walks the tab stops one step at a time.
// A 4-entry command queue lets the parser run ahead of a stalled result.
// Reset is asynchronous; no clearing pass.
// ----------------------------------------------------------------------------
module vt_escape_cursor_tracker #(
    parameter int MAX_PARAMS = vtc_pkg::MAX_PARAMS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    vtc_byte_if.sink     in_ch,
    vtc_result_if.source out_ch,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [12:0]  cfg_wdata
);
    localparam logic REG_COLS = 1'b0;
    localparam logic REG_ROWS = 1'b1;

    logic [12:0]   cols_reg, cols_next, rows_reg, rows_next;
    logic [11:0]   cmax, rmax;
    logic          push, full, pop, nonempty;
    vtc_pkg::cmd_t push_cmd, head;

    always_comb
    begin
        cols_next = (cfg_we && cfg_index == REG_COLS) ? cfg_wdata : cols_reg;
        rows_next = (cfg_we && cfg_index == REG_ROWS) ? cfg_wdata : rows_reg;
        cmax      = (cols_reg == '0) ? 12'd0
                  : (cols_reg > 13'd4096) ? 12'd4095 : 12'(cols_reg - 13'd1);
        rmax      = (rows_reg == '0) ? 12'd0
                  : (rows_reg > 13'd4096) ? 12'd4095 : 12'(rows_reg - 13'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= vtc_pkg::COLS_RESET;
            rows_reg <= vtc_pkg::ROWS_RESET;
        end
        else
        begin
            cols_reg <= cols_next;
            rows_reg <= rows_next;
        end
    end

    vtc_front #(.MAX_PARAMS(MAX_PARAMS)) u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full)
    );

    vtc_cmd_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wdata    (push_cmd),
        .full     (full),
        .pop      (pop),
        .rdata    (head),
        .nonempty (nonempty)
    );

    vtc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head),
        .cmd_valid (nonempty),
        .pop       (pop),
        .cmax      (cmax),
        .rmax      (rmax),
        .out_ch    (out_ch)
    );
endmodule

[test/vtc_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtc_tb_pkg
// Stream byte codes and register indexes shared by the cursor tracker bench.
// ----------------------------------------------------------------------------
package vtc_tb_pkg;

    localparam logic [7:0] C_BS  = 8'h08;
    localparam logic [7:0] C_HT  = 8'h09;
    localparam logic [7:0] C_LF  = 8'h0A;
    localparam logic [7:0] C_CR  = 8'h0D;
    localparam logic [7:0] C_DEL = 8'h7F;
    localparam logic [7:0] C_SP  = 8'h20;
    localparam logic [7:0] C_LT  = 8'h3C;
    localparam logic [7:0] C_LM  = 8'h6D;

    typedef enum logic {
        REG_COLUMNS = 1'b0,
        REG_ROWS    = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [11:0] col;
        logic [11:0] row;
        logic        wrap;
        logic [15:0] scrolled;
        logic        sb_clear;
        logic        alt;
    } cursor_report_t;

endpackage

[test/vtc_cursor_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtc_cursor_checker
// Watches byte and report transfers, tracks terminal cursor state per byte
// and compares every report against the predicted cursor.
// ----------------------------------------------------------------------------
module vtc_cursor_checker
    import vtc_pkg::*;
    import vtc_tb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    vtc_byte_if          in_ch,
    vtc_result_if        out_ch,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [12:0]  cfg_wdata,
    output int           mismatches,
    output int           outstanding
);

    localparam int NPRM = 16;
    localparam int TABW = 8;

    typedef enum int { PM_GROUND, PM_ESC, PM_CSI, PM_STRING, PM_CHARSET } pmode_t;

    localparam int unsigned ZLO[18] = '{'h80, 'hAD, 'h300, 'h483, 'h591, 'h610, 'h64B,
        'h1160, 'h200B, 'h202A, 'h2060, 'h20D0, 'hD800, 'hFE00, 'hFE20, 'hFEFF,
        'hE0100, 'h110000};
    localparam int unsigned ZHI[18] = '{'h9F, 'hAD, 'h36F, 'h489, 'h5BD, 'h61A, 'h65F,
        'h11FF, 'h200F, 'h202E, 'h2064, 'h20FF, 'hDFFF, 'hFE0F, 'hFE2F, 'hFEFF,
        'hE01EF, 'h1FFFFF};
    localparam int unsigned WLO[15] = '{'h1100, 'h2E80, 'h3041, 'h3400, 'h4E00, 'hA000,
        'hAC00, 'hF900, 'hFE30, 'hFF00, 'hFFE0, 'h1F300, 'h1F900, 'h20000, 'h30000};
    localparam int unsigned WHI[15] = '{'h115F, 'h303E, 'h33FF, 'h4DBF, 'h9FFF, 'hA4CF,
        'hD7A3, 'hFAFF, 'hFE4F, 'hFF60, 'hFFE6, 'h1F64F, 'h1F9FF, 'h2FFFD, 'h3FFFD};

    logic [12:0] cols_reg, rows_reg;
    pmode_t pmode;
    int col, row, pwrap, awrap, reg_on, reg_top, reg_bot;
    int sv_ok, sv_col, sv_row, sv_wrap, alt, alt_col, alt_row, str_esc;
    int unsigned u_acc;
    int u_have, u_want;
    int prm[NPRM];
    int pcount, pcur, pseen, priv;
    int step_scr, step_clr;
    cursor_report_t expected_reports[$];

    function automatic int eff(logic [12:0] v);
        if (v == 0) return 1;
        if (v > 4096) return 4096;
        return int'(v);
    endfunction

    function automatic int glyph_width(int unsigned cp);
        for (int i = 0; i < 18; i++)
            if (cp >= ZLO[i] && cp <= ZHI[i]) return 0;
        for (int i = 0; i < 15; i++)
            if (cp >= WLO[i] && cp <= WHI[i]) return 2;
        return 1;
    endfunction

    function automatic int sat16(int v);
        return v < 0 ? 0 : (v > 65535 ? 65535 : v);
    endfunction

    task automatic scroll_off(int n);
        if (!reg_on)
        begin
            step_scr += n;
            if (step_scr > 65535) step_scr = 65535;
        end
    endtask

    task automatic next_line();
        int bottom;
        bottom = reg_on ? reg_bot : eff(rows_reg) - 1;
        if (row + 1 > bottom)
        begin
            scroll_off(1);
            row = bottom;
        end
        else
            row++;
    endtask

    task automatic clamp_pos();
        if (col >= eff(cols_reg)) col = eff(cols_reg) - 1;
        if (row >= eff(rows_reg)) row = eff(rows_reg) - 1;
    endtask

    task automatic save_pos();
        sv_ok = 1; sv_col = col; sv_row = row; sv_wrap = pwrap;
    endtask

    task automatic restore_pos();
        if (sv_ok)
        begin
            col = sv_col; row = sv_row; pwrap = sv_wrap;
        end
    endtask

    task automatic enter_alt();
        if (!alt)
        begin
            alt = 1; alt_col = col; alt_row = row;
        end
    endtask

    task automatic leave_alt(int restore);
        if (alt)
        begin
            alt = 0;
            if (restore)
            begin
                col = alt_col; row = alt_row; pwrap = 0;
            end
        end
    endtask

    task automatic place_glyph(int unsigned cp);
        int last, w, nx;
        last = eff(cols_reg) - 1;
        if (cp == C_CR)
        begin
            col = 0; pwrap = 0; return;
        end
        if (cp == C_LF)
        begin
            col = 0; pwrap = 0; next_line(); return;
        end
        if (cp == C_BS)
        begin
            pwrap = 0; if (col > 0) col--; return;
        end
        if (cp == C_HT)
        begin
            nx = (col / TABW + 1) * TABW;
            col = nx < eff(cols_reg) ? nx : last;
            return;
        end
        if (cp < 'h20 || cp == C_DEL) return;
        w = glyph_width(cp);
        if (pwrap)
        begin
            pwrap = 0; col = 0; next_line();
        end
        if (w == 0) return;
        if (col + w > last)
        begin
            if (awrap)
            begin
                if (w == 1 && col == last)
                begin
                    pwrap = 1; return;
                end
                col = 0; next_line(); col = w;
            end
            else
                col = last;
            return;
        end
        col += w;
    endtask

    task automatic clear_params();
        pcount = 0; pcur = 0; pseen = 0; priv = 0;
    endtask

    task automatic push_param();
        if (pcount < NPRM)
        begin
            prm[pcount] = pcur;
            pcount++;
        end
        pcur = 0;
    endtask

    function automatic int param_or_one(int i);
        if (pseen && i < pcount) return prm[i] == 0 ? 1 : prm[i];
        return 1;
    endfunction

    task automatic run_csi(logic [7:0] f);
        int n, nx, p1, p2;
        n = param_or_one(0);
        case (f)
            B_UH, B_LF_:
            begin
                row = sat16(n - 1); col = sat16(param_or_one(1) - 1); pwrap = 0;
            end
            B_UA: row = sat16(row - n);
            B_UB, B_LE: row = sat16(row + n);
            B_UC, B_LA:
            begin
                col = sat16(col + n); pwrap = 0;
            end
            B_UD:
            begin
                col = sat16(col - n); pwrap = 0;
            end
            B_UE:
            begin
                col = 0; row = sat16(row + n);
            end
            B_UF:
            begin
                col = 0; row = sat16(row - n);
            end
            B_UG, B_BTICK:
            begin
                col = sat16(n - 1); pwrap = 0;
            end
            B_LD: row = sat16(n - 1);
            B_UI:
            begin
                for (int i = 0; i < n; i++)
                begin
                    nx = (col / TABW + 1) * TABW;
                    if (nx >= eff(cols_reg))
                    begin
                        col = eff(cols_reg) - 1;
                        break;
                    end
                    col = nx;
                end
                pwrap = 0;
            end
            B_UZ:
            begin
                for (int i = 0; i < n && col > 0; i++)
                    col = ((col - 1) / TABW) * TABW;
                pwrap = 0;
            end
            B_US: scroll_off(n);
            B_LR:
            begin
                p1 = pcount >= 2 ? prm[0] : 0;
                p2 = pcount >= 2 ? prm[1] : 0;
                if (pcount < 2 || (p1 == 0 && p2 == 0))
                begin
                    reg_on = 0; col = 0; row = 0;
                end
                else
                begin
                    if (p2 > eff(rows_reg)) p2 = eff(rows_reg);
                    if (p1 >= 1 && p2 >= 1 && p1 < p2)
                    begin
                        reg_on = 1; reg_top = p1 - 1; reg_bot = p2 - 1;
                        col = 0; row = reg_top;
                    end
                end
                pwrap = 0;
            end
            B_UJ: if (pseen && pcount > 0 && prm[0] == 3) step_clr = 1;
            B_LS: save_pos();
            B_LU: restore_pos();
            default: ;
        endcase
        clamp_pos();
    endtask

    task automatic run_modes(int on);
        for (int i = 0; i < pcount; i++)
        begin
            case (prm[i])
                MODE_AWM:
                    if (on) awrap = 1;
                    else
                    begin
                        awrap = 0; pwrap = 0;
                    end
                MODE_ALT47, MODE_ALT: if (on) enter_alt(); else leave_alt(0);
                MODE_SAVE: if (on) save_pos(); else restore_pos();
                MODE_ALTSAV:
                    if (on)
                    begin
                        if (!alt)
                        begin
                            save_pos(); enter_alt();
                        end
                    end
                    else
                        leave_alt(1);
                default: ;
            endcase
        end
        clamp_pos();
    endtask

    task automatic utf8_in(logic [7:0] b);
        int unsigned cp;
        if (u_have == 0)
        begin
            if (b[7:5] == 3'b110)
            begin
                u_want = 2; u_acc = b[4:0];
            end
            else if (b[7:4] == 4'b1110)
            begin
                u_want = 3; u_acc = b[3:0];
            end
            else if (b[7:3] == 5'b11110)
            begin
                u_want = 4; u_acc = b[2:0];
            end
            else
                return;
            u_have = 1;
        end
        else
        begin
            u_acc = ((u_acc << 6) | b[5:0]) & 32'h1FFFFF;
            u_have++;
        end
        if (u_have >= u_want)
        begin
            cp = u_acc;
            u_acc = 0; u_have = 0; u_want = 0;
            place_glyph(cp);
        end
    endtask

    task automatic track_byte(input logic [7:0] b, output cursor_report_t r);
        int cm, rm;
        step_scr = 0; step_clr = 0;
        case (pmode)
            PM_GROUND:
                if (b == B_ESC) pmode = PM_ESC;
                else if (b == C_CR || b == C_LF || b == C_BS || b == C_HT || b == B_BEL)
                    place_glyph(b);
                else if (b >= C_SP && b <= B_TILDE) place_glyph(b);
                else if (b[7]) utf8_in(b);
            PM_ESC:
            begin
                pmode = PM_GROUND;
                if (b == B_LBRK)
                begin
                    clear_params(); pmode = PM_CSI;
                end
                else if (b == B_RBRK || b == B_P || b == B_USCORE || b == B_CARET)
                begin
                    str_esc = 0; pmode = PM_STRING;
                end
                else if (b == B_LPAR || b == B_RPAR || b == B_STAR || b == B_PLUS)
                    pmode = PM_CHARSET;
                else if (b == B_7) save_pos();
                else if (b == B_8) restore_pos();
                else if (b == B_UD) next_line();
                else if (b == B_UM)
                begin
                    if (row <= (reg_on ? reg_top : 0)) row = reg_on ? reg_top : 0;
                    else row--;
                end
                else if (b == B_UE)
                begin
                    col = 0; next_line();
                end
                else if (b == B_LC)
                begin
                    awrap = 1; alt = 0; reg_on = 0; col = 0; row = 0; pwrap = 0;
                    sv_ok = 0; step_clr = 1;
                end
            end
            PM_CSI:
                if (b >= B_0 && b <= B_9)
                begin
                    pcur = pcur * 10 + (b - B_0);
                    if (pcur > 65535) pcur = 65535;
                    pseen = 1;
                end
                else if (b == B_SEMI || b == B_COLON)
                begin
                    push_param(); pseen = 1;
                end
                else if (b == B_QMARK) priv = 1;
                else if (b == B_ESC)
                begin
                    clear_params(); pmode = PM_ESC;
                end
                else if (b >= B_AT && b <= B_TILDE)
                begin
                    push_param();
                    if (b == B_LH || b == B_LL)
                    begin
                        if (priv) run_modes(b == B_LH);
                    end
                    else
                        run_csi(b);
                    clear_params();
                    pmode = PM_GROUND;
                end
            PM_STRING:
                if (str_esc)
                begin
                    if (b == B_BSLASH) pmode = PM_GROUND;
                    str_esc = 0;
                end
                else if (b == B_BEL) pmode = PM_GROUND;
                else if (b == B_ESC) str_esc = 1;
            default: pmode = PM_GROUND;
        endcase
        cm = eff(cols_reg) - 1;
        rm = eff(rows_reg) - 1;
        r.col      = 12'(col > cm ? cm : col);
        r.row      = 12'(row > rm ? rm : row);
        r.wrap     = pwrap[0];
        r.scrolled = 16'(step_scr);
        r.sb_clear = step_clr[0];
        r.alt      = alt[0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cursor_report_t got, want, pred;
        if (!rst_n)
        begin
            cols_reg = COLS_RESET; rows_reg = ROWS_RESET;
            pmode = PM_GROUND;
            col = 0; row = 0; pwrap = 0; awrap = 1;
            reg_on = 0; reg_top = 0; reg_bot = 0;
            sv_ok = 0; sv_col = 0; sv_row = 0; sv_wrap = 0;
            alt = 0; alt_col = 0; alt_row = 0; str_esc = 0;
            u_acc = 0; u_have = 0; u_want = 0;
            clear_params();
            expected_reports.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_COLUMNS) cols_reg = cfg_wdata;
                else rows_reg = cfg_wdata;
            end
            if (in_ch.valid && in_ch.ready)
            begin
                track_byte(in_ch.data_byte, pred);
                expected_reports.insert(expected_reports.size(), pred);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.cursor_col, out_ch.cursor_row, out_ch.wrap_pending,
                        out_ch.scrolled_lines, out_ch.scrollback_clear,
                        out_ch.alt_screen_on};
                if (expected_reports.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected report col=%0d row=%0d", $realtime,
                                 got.col, got.row);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: report mismatch exp col=%0d row=%0d wrap=%0d ",
                                      "scr=%0d clr=%0d alt=%0d | got col=%0d row=%0d ",
                                      "wrap=%0d scr=%0d clr=%0d alt=%0d"}, $realtime,
                                     want.col, want.row, want.wrap, want.scrolled,
                                     want.sb_clear, want.alt, got.col, got.row,
                                     got.wrap, got.scrolled, got.sb_clear, got.alt);
                    end
                end
            end
            outstanding = expected_reports.size();
        end
    end

endmodule

[test/tb_vt_escape_cursor_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vt_escape_cursor_tracker
// Drives terminal byte streams (text, UTF-8, controls, escape, CSI and
// string sequences, noise) across several screen sizes with random sender
// bursts and receiver stalls; the checker compares every cursor report.
// ----------------------------------------------------------------------------
module tb_vt_escape_cursor_tracker;
    import vtc_pkg::*;
    import vtc_tb_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int BYTES_PER_SETTING = 230;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [12:0] cfg_wdata;
    int          mismatches;
    int          outstanding;
    int          burst_left;
    int          bytes_sent;
    int          stall_cnt;

    vtc_byte_if   in_ch();
    vtc_result_if out_ch();

    vt_escape_cursor_tracker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    vtc_cursor_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        out_ch.ready = 1'b0;
        stall_cnt = 0;
        forever
        begin
            @(posedge clk);
            stall_cnt++;
            case (stall_cnt[9:8])
                2'd0: out_ch.ready <= 1'b1;
                2'd1: out_ch.ready <= 1'($urandom_range(0, 1));
                2'd2: out_ch.ready <= (stall_cnt[2:0] != 3'd0);
                default: out_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic send_byte(logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_screen(logic [12:0] columns, logic [12:0] rows);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_COLUMNS;
        cfg_wdata <= columns;
        @(posedge clk);
        cfg_index <= REG_ROWS;
        cfg_wdata <= rows;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_number(int v);
        if (v >= 10) send_number(v / 10);
        send_byte(B_0 + 8'(v % 10));
    endtask

    task automatic send_cp(int unsigned cp);
        if (cp < 'h80)
            send_byte(8'(cp));
        else if (cp < 'h800)
        begin
            send_byte(8'hC0 | 8'(cp >> 6));
            send_byte(8'h80 | 8'(cp & 'h3F));
        end
        else if (cp < 'h10000)
        begin
            send_byte(8'hE0 | 8'(cp >> 12));
            send_byte(8'h80 | 8'((cp >> 6) & 'h3F));
            send_byte(8'h80 | 8'(cp & 'h3F));
        end
        else
        begin
            send_byte(8'hF0 | 8'((cp >> 18) & 'h7));
            send_byte(8'h80 | 8'((cp >> 12) & 'h3F));
            send_byte(8'h80 | 8'((cp >> 6) & 'h3F));
            send_byte(8'h80 | 8'(cp & 'h3F));
        end
    endtask

    function automatic int pick_param();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom_range(65536, 999999);
            2: return $urandom_range(0, 65535);
            3: return 3;
            4, 5: return $urandom_range(1, 40);
            default: return $urandom_range(1, 9);
        endcase
    endfunction

    function automatic logic [7:0] pick_final();
        logic [7:0] finals[27];
        finals = '{B_UH, B_LF_, B_UA, B_UB, B_LE, B_UC, B_LA, B_UD, B_UE, B_UF, B_UG,
                   B_BTICK, B_LD, B_UI, B_UZ, B_US, B_LR, B_UJ, B_LS, B_LU, B_LH,
                   B_LL, C_LM, B_AT, B_TILDE, B_UI, B_LR};
        return finals[$urandom_range(0, 26)];
    endfunction

    task automatic send_csi();
        int n;
        send_byte(B_ESC);
        send_byte(B_LBRK);
        if ($urandom_range(0, 7) == 0) send_byte(B_QMARK);
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 20) : $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
        begin
            if (i > 0) send_byte($urandom_range(0, 5) == 0 ? B_COLON : B_SEMI);
            if ($urandom_range(0, 6) != 0) send_number(pick_param());
            case ($urandom_range(0, 19))
                0: send_byte(C_SP);
                1: send_byte(C_LT);
                2: send_byte(8'($urandom_range(0, 31)) == B_ESC ? C_CR
                             : 8'($urandom_range(0, 31)));
                3: send_byte(8'($urandom_range(128, 255)));
                4: if ($urandom_range(0, 3) == 0) send_byte(B_ESC);
                default: ;
            endcase
        end
        send_byte(pick_final());
    endtask

    task automatic send_mode();
        int modes[6];
        modes = '{7, 47, 1047, 1048, 1049, 25};
        send_byte(B_ESC);
        send_byte(B_LBRK);
        send_byte(B_QMARK);
        send_number(modes[$urandom_range(0, 5)]);
        if ($urandom_range(0, 3) == 0)
        begin
            send_byte(B_SEMI);
            send_number(modes[$urandom_range(0, 5)]);
        end
        send_byte($urandom_range(0, 1) ? B_LH : B_LL);
    endtask

    task automatic send_escape();
        logic [7:0] intro[4];
        int n;
        intro = '{B_RBRK, B_P, B_USCORE, B_CARET};
        send_byte(B_ESC);
        case ($urandom_range(0, 9))
            0: send_byte(B_7);
            1: send_byte(B_8);
            2: send_byte(B_UD);
            3: send_byte(B_UM);
            4: send_byte(B_UE);
            5: if ($urandom_range(0, 3) == 0) send_byte(B_LC); else send_byte(B_UM);
            6:
            begin
                send_byte($urandom_range(0, 1) ? B_LPAR : B_STAR);
                send_byte(8'($urandom_range(0, 255)));
            end
            7:
            begin
                send_byte(intro[$urandom_range(0, 3)]);
                n = $urandom_range(0, 8);
                for (int i = 0; i < n; i++)
                    send_byte($urandom_range(0, 5) == 0 ? B_ESC : 8'($urandom_range(32, 255)));
                if ($urandom_range(0, 1))
                    send_byte(B_BEL);
                else
                begin
                    send_byte(B_ESC);
                    send_byte(B_BSLASH);
                end
            end
            8: send_byte(8'($urandom_range(0, 255)));
            default: send_byte(B_UD);
        endcase
    endtask

    task automatic send_unicode();
        case ($urandom_range(0, 6))
            0: send_cp($urandom_range('h80, 'h7FF));
            1: send_cp($urandom_range('h4E00, 'h9FFF));
            2: send_cp($urandom_range('h300, 'h36F));
            3: send_cp($urandom_range('h1F300, 'h1F9FF));
            4: send_cp($urandom_range('h110000, 'h1FFFFF));
            5: send_cp($urandom_range('h800, 'hFFFF));
            default:
            begin
                send_byte(8'hE4);
                send_byte(C_SP + 8'($urandom_range(1, 90)));
                send_byte(8'hB8);
                send_byte(8'h80);
            end
        endcase
    endtask

    task automatic send_mix(int count);
        int stop;
        int n;
        logic [7:0] ctl[7];
        ctl = '{C_CR, C_LF, C_BS, C_HT, B_BEL, C_DEL, 8'h01};
        stop = bytes_sent + count;
        while (bytes_sent < stop)
        begin
            case ($urandom_range(0, 15))
                0, 1, 2:
                begin
                    n = $urandom_range(1, 12);
                    for (int i = 0; i < n; i++) send_byte(8'($urandom_range(32, 126)));
                end
                3, 4: send_byte(ctl[$urandom_range(0, 6)]);
                5, 6, 7, 8: send_csi();
                9, 10: send_mode();
                11, 12: send_escape();
                13, 14: send_unicode();
                default: send_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_COLUMNS;
        cfg_wdata       = '0;
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        burst_left      = 0;
        bytes_sent      = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'h41);
        send_byte(C_HT);
        send_byte(C_BS);
        send_byte(C_CR);
        send_byte(C_LF);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_cp('h4E00);
        send_byte(B_ESC);
        send_byte(B_LBRK);
        send_byte(B_0 + 8'd3);
        send_byte(B_UJ);
        send_byte(B_ESC);
        send_byte(B_LC);
        send_byte(C_DEL);

        set_screen(13'd80, 13'd25);
        send_mix(BYTES_PER_SETTING);
        set_screen(13'd1, 13'd1);
        send_mix(BYTES_PER_SETTING);
        set_screen(13'd4096, 13'd4096);
        send_mix(BYTES_PER_SETTING);
        set_screen(13'd0, 13'd0);
        send_mix(BYTES_PER_SETTING / 2);
        set_screen(13'd8191, 13'd8191);
        send_mix(BYTES_PER_SETTING / 2);
        set_screen(13'd10, 13'd4);
        send_mix(BYTES_PER_SETTING);
        set_screen(13'($urandom_range(2, 200)), 13'($urandom_range(2, 60)));
        send_mix(BYTES_PER_SETTING);
        set_screen(13'd40, 13'd12);
        send_mix(BYTES_PER_SETTING);

        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
design/vtc_pkg.sv
design/vtc_byte_if.sv
design/vtc_result_if.sv
design/vtc_cmd_fifo.sv
design/vtc_front.sv
design/vtc_back.sv
design/vt_escape_cursor_tracker.sv
test/vtc_tb_pkg.sv
test/vtc_cursor_checker.sv
test/tb_vt_escape_cursor_tracker.sv
